FILE: src/amsgrad_pkg.sv
// ----------------------------------------------------------------------------
// amsgrad_pkg
// Shared types and constants of the AMSGrad parameter update engine.
// ----------------------------------------------------------------------------
`default_nettype none

package amsgrad_pkg;

  // Configuration port
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 24;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_LEARNING_RATE = 2'd0,
    REG_FIRST_DECAY   = 2'd1,
    REG_SECOND_DECAY  = 2'd2
  } cfg_reg_t;

  localparam logic [23:0] LEARNING_RATE_RESET = 24'd16777;
  localparam logic [15:0] FIRST_DECAY_RESET   = 16'd58982;
  localparam logic [15:0] SECOND_DECAY_RESET  = 16'd65470;

  // Arithmetic widths
  localparam int ROOT_W     = 32;            // floor(sqrt) of a Q16.48 value
  localparam int DEN_W      = ROOT_W + 1;    // root plus epsilon
  localparam int QUOT_W     = 56;            // rounded Q8.48 numerator / quotient
  localparam int SQRT_STEPS = 4;             // root bits per sqrt stage
  localparam int DIV_STEPS  = 4;             // quotient bits per divider stage

  // Epsilon: 1e-7 rounded to Q8.24
  localparam logic [DEN_W-1:0] EPS = 33'd2;

  // One input word
  typedef struct packed {
    logic [15:0]        param_address;
    logic signed [31:0] gradient;
    logic signed [31:0] current_value;
  } item_t;

  // One result word
  typedef struct packed {
    logic signed [31:0] new_value;
    logic               saturated;
  } result_t;

endpackage

`default_nettype wire

FILE: src/amsgrad_stream_if.sv
// ----------------------------------------------------------------------------
// amsgrad_stream_if
// Valid/ready stream channel carrying one word per accepted handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface amsgrad_stream_if #(
  parameter type word_t = logic
) ();

  logic  valid;
  logic  ready;
  word_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);

endinterface

`default_nettype wire

FILE: src/amsgrad_ram.sv
// ----------------------------------------------------------------------------
// amsgrad_ram
// Generic single-write, single-read RAM with registered, read-first output.
// ----------------------------------------------------------------------------
`default_nettype none

module amsgrad_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                                  clk,
  input  wire logic                                  we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                      wdata,
  input  wire logic                                  re,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port, and read port returning the old contents on a collision
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: src/amsgrad_sqrt.sv
// ----------------------------------------------------------------------------
// amsgrad_sqrt
// Pipelined digit-by-digit integer square root, a few root bits per stage,
// with a sideband word carried alongside.
// ----------------------------------------------------------------------------
`default_nettype none

module amsgrad_sqrt #(
  parameter int SIDE_W = 8
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   ce,
  input  wire logic                                   in_valid,
  input  wire logic [2*amsgrad_pkg::ROOT_W-1:0]       in_x,
  input  wire logic [SIDE_W-1:0]                      in_side,
  output logic                                        out_valid,
  output logic      [amsgrad_pkg::ROOT_W-1:0]         out_root,
  output logic      [SIDE_W-1:0]                      out_side
);

  localparam int RW     = amsgrad_pkg::ROOT_W;
  localparam int REM_W  = RW + 2;
  localparam int RAD_W  = 2 * RW;
  localparam int STEPS  = amsgrad_pkg::SQRT_STEPS;
  localparam int STAGES = RW / STEPS;

  logic              vld  [STAGES+1];
  logic [RAD_W-1:0]  rad  [STAGES+1];
  logic [REM_W-1:0]  rem  [STAGES+1];
  logic [RW-1:0]     root [STAGES+1];
  logic [SIDE_W-1:0] side [STAGES+1];

  logic [RAD_W-1:0]  rad_next  [STAGES];
  logic [REM_W-1:0]  rem_next  [STAGES];
  logic [RW-1:0]     root_next [STAGES];

  // Stage zero is the incoming word
  assign vld[0]  = in_valid;
  assign rad[0]  = in_x;
  assign rem[0]  = '0;
  assign root[0] = '0;
  assign side[0] = in_side;

  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    // Resolve a group of root bits
    always_comb begin
      logic [REM_W+1:0] trial_rem;
      logic [REM_W+1:0] trial_sub;
      logic [REM_W-1:0] r;
      logic [RW-1:0]    q;
      logic [RAD_W-1:0] x;
      r = rem[s];
      q = root[s];
      x = rad[s];
      for (int i = 0; i < STEPS; i++) begin
        trial_rem = {r, x[RAD_W-1 -: 2]};
        trial_sub = {2'b00, q, 2'b01};
        if (trial_rem >= trial_sub) begin
          trial_rem = trial_rem - trial_sub;
          q = {q[RW-2:0], 1'b1};
        end else begin
          q = {q[RW-2:0], 1'b0};
        end
        r = trial_rem[REM_W-1:0];
        x = {x[RAD_W-3:0], 2'b00};
      end
      rem_next[s]  = r;
      root_next[s] = q;
      rad_next[s]  = x;
    end

    // Advance valid bits
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else if (ce) begin
        vld[s+1] <= vld[s];
      end
    end

    // Advance the partial root and sideband
    always_ff @(posedge clk) begin
      if (ce) begin
        rad[s+1]  <= rad_next[s];
        rem[s+1]  <= rem_next[s];
        root[s+1] <= root_next[s];
        side[s+1] <= side[s];
      end
    end
  end

  assign out_valid = vld[STAGES];
  assign out_root  = root[STAGES];
  assign out_side  = side[STAGES];

endmodule

`default_nettype wire

FILE: src/amsgrad_div.sv
// ----------------------------------------------------------------------------
// amsgrad_div
// Pipelined restoring unsigned divider, a few quotient bits per stage,
// with a sideband word carried alongside.
// ----------------------------------------------------------------------------
`default_nettype none

module amsgrad_div #(
  parameter int SIDE_W = 8
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               ce,
  input  wire logic                               in_valid,
  input  wire logic [amsgrad_pkg::QUOT_W-1:0]     in_num,
  input  wire logic [amsgrad_pkg::DEN_W-1:0]      in_den,
  input  wire logic [SIDE_W-1:0]                  in_side,
  output logic                                    out_valid,
  output logic      [amsgrad_pkg::QUOT_W-1:0]     out_quot,
  output logic      [SIDE_W-1:0]                  out_side
);

  localparam int NW     = amsgrad_pkg::QUOT_W;
  localparam int DW     = amsgrad_pkg::DEN_W;
  localparam int STEPS  = amsgrad_pkg::DIV_STEPS;
  localparam int STAGES = NW / STEPS;

  logic              vld  [STAGES+1];
  logic [NW-1:0]     nq   [STAGES+1];   // numerator bits out the top, quotient in the bottom
  logic [DW-1:0]     rem  [STAGES+1];
  logic [DW-1:0]     den  [STAGES+1];
  logic [SIDE_W-1:0] side [STAGES+1];

  logic [NW-1:0] nq_next  [STAGES];
  logic [DW-1:0] rem_next [STAGES];

  assign vld[0]  = in_valid;
  assign nq[0]   = in_num;
  assign rem[0]  = '0;
  assign den[0]  = in_den;
  assign side[0] = in_side;

  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    // Resolve a group of quotient bits
    always_comb begin
      logic [DW:0]   trial;
      logic [DW-1:0] r;
      logic [NW-1:0] x;
      r = rem[s];
      x = nq[s];
      for (int i = 0; i < STEPS; i++) begin
        trial = {r, x[NW-1]};
        x = {x[NW-2:0], 1'b0};
        if (trial >= {1'b0, den[s]}) begin
          trial = trial - {1'b0, den[s]};
          x[0] = 1'b1;
        end
        r = trial[DW-1:0];
      end
      rem_next[s] = r;
      nq_next[s]  = x;
    end

    // Advance valid bits
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else if (ce) begin
        vld[s+1] <= vld[s];
      end
    end

    // Advance partial quotient, divisor and sideband
    always_ff @(posedge clk) begin
      if (ce) begin
        nq[s+1]   <= nq_next[s];
        rem[s+1]  <= rem_next[s];
        den[s+1]  <= den[s];
        side[s+1] <= side[s];
      end
    end
  end

  assign out_valid = vld[STAGES];
  assign out_quot  = nq[STAGES];
  assign out_side  = side[STAGES];

endmodule

`default_nettype wire

FILE: src/amsgrad_parameter_update.sv
// ----------------------------------------------------------------------------
// amsgrad_parameter_update
// AMSGrad optimizer step: per-parameter moment stores and a saturated update.
// ----------------------------------------------------------------------------
// Takes one parameter word per clock and returns one result word per clock
// unless the result channel holds the pipeline. The moment stores are read,
// updated and written back in a single stage each (first/second moment, then
// the running maximum), with one-word forwarding so back-to-back hits on one
// address are exact. The square root (8 stages) and the divider (14 stages)
// are fully pipelined. After reset the stores are swept to zero, one entry per
// cycle; no word is taken during that sweep, while configuration writes are
// taken at all times. Configuration must only be written while the pipeline is
// empty. Addresses wrap modulo PARAM_COUNT.
// ----------------------------------------------------------------------------
`default_nettype none

module amsgrad_parameter_update #(
  parameter int PARAM_COUNT = 65536
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_write,
  input  wire logic [amsgrad_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [amsgrad_pkg::CFG_DATA_W-1:0]   cfg_data,
  amsgrad_stream_if.sink                            items,
  amsgrad_stream_if.source                          results
);

  localparam int ADDR_W  = (PARAM_COUNT > 1) ? $clog2(PARAM_COUNT) : 1;
  localparam int RED_W   = 41;
  localparam int RW      = amsgrad_pkg::ROOT_W;
  localparam int DW      = amsgrad_pkg::DEN_W;
  localparam int QW      = amsgrad_pkg::QUOT_W;
  localparam int SQ_SIDE = QW + 1 + 32;
  localparam int DV_SIDE = 1 + 32;

  // Fold an address by PARAM_COUNT, eight restoring steps at a time
  function automatic logic [RED_W-1:0] fold_addr(input logic [RED_W-1:0] a, input int top);
    logic [RED_W-1:0] r;
    logic [RED_W-1:0] lim;
    r = a;
    for (int k = top; k > top - 8; k--) begin
      lim = RED_W'(PARAM_COUNT) << k;
      if (r >= lim) begin
        r = r - lim;
      end
    end
    return r;
  endfunction

  // ---------------------------------------------------------------- config
  logic [23:0] learning_rate;
  logic [15:0] first_decay;
  logic [15:0] second_decay;

  // Write configuration registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      learning_rate <= amsgrad_pkg::LEARNING_RATE_RESET;
      first_decay   <= amsgrad_pkg::FIRST_DECAY_RESET;
      second_decay  <= amsgrad_pkg::SECOND_DECAY_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        amsgrad_pkg::REG_LEARNING_RATE: learning_rate <= cfg_data;
        amsgrad_pkg::REG_FIRST_DECAY:   first_decay   <= cfg_data[15:0];
        amsgrad_pkg::REG_SECOND_DECAY:  second_decay  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------- clearing pass
  logic              clearing;
  logic [ADDR_W-1:0] clear_addr;

  // Sweep every store entry to zero after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing   <= 1'b1;
      clear_addr <= '0;
    end else if (clearing) begin
      if (clear_addr == ADDR_W'(PARAM_COUNT - 1)) begin
        clearing <= 1'b0;
      end
      clear_addr <= clear_addr + ADDR_W'(1);
    end
  end

  // ------------------------------------------------------ pipeline control
  logic ce;
  logic take;
  logic out_valid;
  amsgrad_pkg::result_t out_word;

  assign ce          = !out_valid || results.ready;
  assign items.ready = ce && !clearing;
  assign take        = items.valid && items.ready;

  // ------------------------------------------------ stage 1: square, fold
  logic               s1_valid;
  logic [15:0]        s1_addr;
  logic signed [31:0] s1_g;
  logic signed [31:0] s1_w;
  logic [63:0]        s1_gsq;
  logic [32:0]        g_ext;
  logic [32:0]        g_abs;
  logic [RED_W-1:0]   addr_hi;
  logic [RED_W-1:0]   addr_lo;
  logic [ADDR_W-1:0]  rd_addr;

  assign g_ext   = {items.payload.gradient[31], items.payload.gradient};
  assign g_abs   = g_ext[32] ? -g_ext : g_ext;
  assign addr_hi = fold_addr(RED_W'(items.payload.param_address), 15);
  assign addr_lo = fold_addr(RED_W'(s1_addr), 7);
  assign rd_addr = addr_lo[ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (ce) begin
      s1_addr <= addr_hi[15:0];
      s1_g    <= items.payload.gradient;
      s1_w    <= items.payload.current_value;
      s1_gsq  <= g_abs[31:0] * g_abs[31:0];
    end
  end

  // ------------------------------------- stage 2: first and second moment
  logic               s2_valid;
  logic [ADDR_W-1:0]  s2_addr;
  logic signed [31:0] s2_g;
  logic signed [31:0] s2_w;
  logic [63:0]        s2_gsq;
  logic [95:0]        mv_q;
  logic               mv_fwd_valid;
  logic [ADDR_W-1:0]  mv_fwd_addr;
  logic signed [31:0] mv_fwd_m;
  logic [63:0]        mv_fwd_v;
  logic signed [31:0] m_old;
  logic [63:0]        v_old;
  logic [16:0]        one_minus_b1;
  logic [16:0]        one_minus_b2;
  logic signed [48:0] m_p1;
  logic signed [49:0] m_p2;
  logic signed [50:0] m_sum;
  logic signed [50:0] m_floor;
  logic signed [31:0] m_new;
  logic [63:0]        v_hi1;
  logic [64:0]        v_hi2;
  logic [31:0]        v_lo1;
  logic [32:0]        v_lo2;
  logic [33:0]        v_lo;
  logic [63:0]        v_new;
  logic               mv_we;
  logic [ADDR_W-1:0]  mv_waddr;
  logic [95:0]        mv_wdata;

  always_ff @(posedge clk) begin
    if (ce) begin
      s2_addr <= rd_addr;
      s2_g    <= s1_g;
      s2_w    <= s1_w;
      s2_gsq  <= s1_gsq;
    end
  end

  // Take the word written in the same edge as the read from the bypass
  assign m_old = (mv_fwd_valid && mv_fwd_addr == s2_addr) ? mv_fwd_m : mv_q[95:64];
  assign v_old = (mv_fwd_valid && mv_fwd_addr == s2_addr) ? mv_fwd_v : mv_q[63:0];

  // m = round((b1*m + (1-b1)*g) / 2^16), ties up
  assign one_minus_b1 = 17'd65536 - {1'b0, first_decay};
  assign m_p1    = $signed({1'b0, first_decay}) * m_old;
  assign m_p2    = $signed({1'b0, one_minus_b1}) * s2_g;
  assign m_sum   = m_p1 + m_p2 + 51'sd32768;
  assign m_floor = m_sum >>> 16;

  always_comb begin
    if (m_floor > 51'sd2147483647) begin
      m_new = 32'sh7FFF_FFFF;
    end else if (m_floor < -51'sd2147483648) begin
      m_new = 32'sh8000_0000;
    end else begin
      m_new = m_floor[31:0];
    end
  end

  // v = round((b2*v + (1-b2)*g^2) / 2^16), split into high and low halves
  assign one_minus_b2 = 17'd65536 - {1'b0, second_decay};
  assign v_hi1 = second_decay * v_old[63:16];
  assign v_hi2 = one_minus_b2 * s2_gsq[63:16];
  assign v_lo1 = second_decay * v_old[15:0];
  assign v_lo2 = one_minus_b2 * s2_gsq[15:0];
  assign v_lo  = 34'(v_lo1) + 34'(v_lo2) + 34'd32768;
  assign v_new = v_hi1 + v_hi2[63:0] + 64'(v_lo[33:16]);

  // Write back, or zero during the clearing pass
  assign mv_we    = clearing || (ce && s2_valid);
  assign mv_waddr = clearing ? clear_addr : s2_addr;
  assign mv_wdata = clearing ? '0 : {m_new, v_new};

  amsgrad_ram #(
    .WIDTH (96),
    .DEPTH (PARAM_COUNT)
  ) u_mv_ram (
    .clk   (clk),
    .we    (mv_we),
    .waddr (mv_waddr),
    .wdata (mv_wdata),
    .re    (ce),
    .raddr (rd_addr),
    .rdata (mv_q)
  );

  // Hold the last written moments for the bypass
  always_ff @(posedge clk) begin
    if (rst) begin
      mv_fwd_valid <= 1'b0;
    end else if (ce && s2_valid) begin
      mv_fwd_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ce && s2_valid) begin
      mv_fwd_addr <= s2_addr;
      mv_fwd_m    <= m_new;
      mv_fwd_v    <= v_new;
    end
  end

  // ----------------------------------- stage 3: running maximum, lr * |m|
  logic               s3_valid;
  logic [ADDR_W-1:0]  s3_addr;
  logic signed [31:0] s3_m;
  logic [63:0]        s3_v;
  logic signed [31:0] s3_w;
  logic [63:0]        vh_q;
  logic               vh_fwd_valid;
  logic [ADDR_W-1:0]  vh_fwd_addr;
  logic [63:0]        vh_fwd;
  logic [63:0]        vh_old;
  logic [63:0]        vh_new;
  logic [32:0]        m_ext;
  logic [32:0]        m_abs;
  logic               vh_we;
  logic [ADDR_W-1:0]  vh_waddr;
  logic [63:0]        vh_wdata;

  always_ff @(posedge clk) begin
    if (ce) begin
      s3_addr <= s2_addr;
      s3_m    <= m_new;
      s3_v    <= v_new;
      s3_w    <= s2_w;
    end
  end

  assign vh_old = (vh_fwd_valid && vh_fwd_addr == s3_addr) ? vh_fwd : vh_q;
  assign vh_new = (s3_v > vh_old) ? s3_v : vh_old;
  assign m_ext  = {s3_m[31], s3_m};
  assign m_abs  = m_ext[32] ? -m_ext : m_ext;

  assign vh_we    = clearing || (ce && s3_valid);
  assign vh_waddr = clearing ? clear_addr : s3_addr;
  assign vh_wdata = clearing ? '0 : vh_new;

  amsgrad_ram #(
    .WIDTH (64),
    .DEPTH (PARAM_COUNT)
  ) u_vh_ram (
    .clk   (clk),
    .we    (vh_we),
    .waddr (vh_waddr),
    .wdata (vh_wdata),
    .re    (ce),
    .raddr (s2_addr),
    .rdata (vh_q)
  );

  // Hold the last written maximum for the bypass
  always_ff @(posedge clk) begin
    if (rst) begin
      vh_fwd_valid <= 1'b0;
    end else if (ce && s3_valid) begin
      vh_fwd_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ce && s3_valid) begin
      vh_fwd_addr <= s3_addr;
      vh_fwd      <= vh_new;
    end
  end

  // -------------------------------------------- stage 4: square root input
  logic               s4_valid;
  logic [63:0]        s4_vh;
  logic [QW-1:0]      s4_prod;
  logic               s4_neg;
  logic signed [31:0] s4_w;

  always_ff @(posedge clk) begin
    if (ce) begin
      s4_vh   <= vh_new;
      s4_prod <= learning_rate * m_abs[31:0];
      s4_neg  <= s3_m[31];
      s4_w    <= s3_w;
    end
  end

  logic               sq_valid;
  logic [RW-1:0]      sq_root;
  logic [SQ_SIDE-1:0] sq_side;

  amsgrad_sqrt #(
    .SIDE_W (SQ_SIDE)
  ) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .ce        (ce),
    .in_valid  (s4_valid),
    .in_x      (s4_vh),
    .in_side   ({s4_prod, s4_neg, s4_w}),
    .out_valid (sq_valid),
    .out_root  (sq_root),
    .out_side  (sq_side)
  );

  // ---------------------------------- stage 5: denominator and rounding
  logic               s5_valid;
  logic [DW-1:0]      s5_den;
  logic [QW-1:0]      s5_num;
  logic [DV_SIDE-1:0] s5_side;
  logic [DW-1:0]      den;

  assign den = {1'b0, sq_root} + amsgrad_pkg::EPS;

  always_ff @(posedge clk) begin
    if (ce) begin
      s5_den  <= den;
      s5_num  <= sq_side[SQ_SIDE-1 -: QW] + QW'(den[DW-1:1]);
      s5_side <= sq_side[DV_SIDE-1:0];
    end
  end

  logic               dv_valid;
  logic [QW-1:0]      dv_quot;
  logic [DV_SIDE-1:0] dv_side;

  amsgrad_div #(
    .SIDE_W (DV_SIDE)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .ce        (ce),
    .in_valid  (s5_valid),
    .in_num    (s5_num),
    .in_den    (s5_den),
    .in_side   (s5_side),
    .out_valid (dv_valid),
    .out_quot  (dv_quot),
    .out_side  (dv_side)
  );

  // ------------------------------------------- output: apply and saturate
  logic signed [QW+1:0] w_ext;
  logic signed [QW+1:0] q_ext;
  logic signed [QW+1:0] res;
  amsgrad_pkg::result_t res_word;

  assign w_ext = (QW+2)'($signed(dv_side[31:0]));
  assign q_ext = $signed({2'b00, dv_quot});
  assign res   = dv_side[32] ? (w_ext + q_ext) : (w_ext - q_ext);

  always_comb begin
    if (res > (QW+2)'(64'sh7FFF_FFFF)) begin
      res_word.new_value = 32'sh7FFF_FFFF;
      res_word.saturated = 1'b1;
    end else if (res < -(QW+2)'(64'sh8000_0000)) begin
      res_word.new_value = 32'sh8000_0000;
      res_word.saturated = 1'b1;
    end else begin
      res_word.new_value = res[31:0];
      res_word.saturated = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      out_word <= res_word;
    end
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      s4_valid  <= 1'b0;
      s5_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (ce) begin
      s1_valid  <= take;
      s2_valid  <= s1_valid;
      s3_valid  <= s2_valid;
      s4_valid  <= s3_valid;
      s5_valid  <= sq_valid;
      out_valid <= dv_valid;
    end
  end

  assign results.valid   = out_valid;
  assign results.payload = out_word;

endmodule

`default_nettype wire

FILE: verif/amsgrad_update_checker.sv
// ----------------------------------------------------------------------------
// amsgrad_update_checker
// Watches the parameter and result channels of the AMSGrad engine, keeps its
// own copy of the moment stores and registers, predicts each updated value
// and compares every result word with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module amsgrad_update_checker
  import amsgrad_pkg::*;
#(
  parameter int PARAM_COUNT = 65536
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_write,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  amsgrad_stream_if                   items,
  amsgrad_stream_if                   results,
  output int                          mismatches,
  output int                          pending
);

  logic [23:0] step_size;
  logic [15:0] beta1;
  logic [15:0] beta2;

  int              mean_grad [PARAM_COUNT];
  longint unsigned mean_sq   [PARAM_COUNT];
  longint unsigned peak_sq   [PARAM_COUNT];

  result_t expected_updates[$];

  assign pending = expected_updates.size();

  // floor of the square root of a 64-bit value, one result bit per pass
  function automatic longint unsigned floor_root(longint unsigned x);
    longint unsigned root;
    longint unsigned trial;
    root = 0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= x) begin
        root = trial;
      end
    end
    return root;
  endfunction

  // advance the stores of one parameter and return the updated value
  function automatic result_t predict_update(item_t w);
    int unsigned     idx;
    longint          g;
    longint          m;
    longint          res;
    longint unsigned gabs;
    longint unsigned gsq;
    longint unsigned v;
    longint unsigned vh;
    longint unsigned denom;
    longint unsigned mabs;
    longint unsigned q;
    longint unsigned b2;
    result_t         r;
    idx = w.param_address % PARAM_COUNT;
    g   = w.gradient;
    // first moment: blend, round half up, arithmetic shift is floor
    m = (longint'(beta1) * longint'(mean_grad[idx])
        + (longint'(65536) - longint'(beta1)) * g + 32768) >>> 16;
    if (m > 64'sd2147483647) m = 64'sd2147483647;
    if (m < -64'sd2147483648) m = -64'sd2147483648;
    mean_grad[idx] = int'(m);
    // second moment: split the blend so nothing overflows
    gabs = (g < 0) ? longint'(-g) : longint'(g);
    gsq  = gabs * gabs;
    b2   = beta2;
    v = b2 * (mean_sq[idx] >> 16) + (64'd65536 - b2) * (gsq >> 16)
        + ((b2 * (mean_sq[idx] & 64'hFFFF) + (64'd65536 - b2) * (gsq & 64'hFFFF)
            + 64'd32768) >> 16);
    mean_sq[idx] = v;
    // running maximum
    vh = peak_sq[idx];
    if (v > vh) vh = v;
    peak_sq[idx] = vh;
    // step, rounded half away from zero on the magnitude
    denom = floor_root(vh) + EPS;
    mabs  = (m < 0) ? longint'(-m) : longint'(m);
    q     = (longint'(step_size) * mabs + denom / 2) / denom;
    res   = (m < 0) ? longint'(w.current_value) + longint'(q)
                    : longint'(w.current_value) - longint'(q);
    r.saturated = 1'b0;
    if (res > 64'sd2147483647) begin
      res = 64'sd2147483647;
      r.saturated = 1'b1;
    end
    if (res < -64'sd2147483648) begin
      res = -64'sd2147483648;
      r.saturated = 1'b1;
    end
    r.new_value = res[31:0];
    return r;
  endfunction

  always @(posedge clk) begin
    result_t e;
    result_t a;
    if (rst) begin
      // clear registers and stores
      step_size <= LEARNING_RATE_RESET;
      beta1     <= FIRST_DECAY_RESET;
      beta2     <= SECOND_DECAY_RESET;
      for (int i = 0; i < PARAM_COUNT; i++) begin
        mean_grad[i] = 0;
        mean_sq[i]   = 0;
        peak_sq[i]   = 0;
      end
      expected_updates.delete();
      mismatches <= 0;
    end else begin
      // track register writes; unknown indexes drop
      if (cfg_write) begin
        case (cfg_reg_t'(cfg_index))
          REG_LEARNING_RATE: step_size <= cfg_data[23:0];
          REG_FIRST_DECAY:   beta1     <= cfg_data[15:0];
          REG_SECOND_DECAY:  beta2     <= cfg_data[15:0];
          default: ;
        endcase
      end
      if (items.valid && items.ready) begin
        expected_updates.push_back(predict_update(items.payload));
      end
      // compare each result word with the oldest prediction
      if (results.valid && results.ready) begin
        a = results.payload;
        if (expected_updates.size() == 0) begin
          $display("%0t: unexpected result word new_value %h saturated %b",
                   $time, a.new_value, a.saturated);
          mismatches <= mismatches + 1;
        end else begin
          e = expected_updates.pop_front();
          if (a.new_value !== e.new_value || a.saturated !== e.saturated) begin
            $display("%0t: expected new_value %h saturated %b, got %h %b",
                     $time, e.new_value, e.saturated, a.new_value, a.saturated);
            mismatches <= mismatches + 1;
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

FILE: verif/amsgrad_parameter_update_test.sv
// ----------------------------------------------------------------------------
// amsgrad_parameter_update_test
// Drives parameter words through the AMSGrad engine over several register
// settings and idle patterns; a checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module amsgrad_parameter_update_test;
  import amsgrad_pkg::*;

  localparam int IDLE_LIMIT = 300000;  // covers the store sweep after reset
  localparam int DRAIN_WAIT = 60;      // extra wait once no prediction is pending
  localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED = 2'd3;

  logic                   clk;
  logic                   rst;
  logic                   cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  int                     mismatches;
  int                     pending;
  int                     send_idle_pct;
  int                     recv_stall_pct;
  bit                     hold_off;
  int                     quiet_cycles;

  amsgrad_stream_if #(.word_t(item_t))   param_ch ();
  amsgrad_stream_if #(.word_t(result_t)) update_ch ();

  amsgrad_parameter_update u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .items     (param_ch),
    .results   (update_ch)
  );

  amsgrad_update_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .items      (param_ch),
    .results    (update_ch),
    .mismatches (mismatches),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    update_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off && !hold_done) begin
        hold_left = 400;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        update_ch.ready <= 1'b0;
      end else begin
        update_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (param_ch.valid && param_ch.ready) || (update_ch.valid && update_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
  endtask

  // set all three registers, write the unmapped index, then drop the write enable
  task automatic set_regs(input logic [23:0] lr, input logic [15:0] b1,
                          input logic [15:0] b2);
    write_reg(REG_LEARNING_RATE, lr);
    write_reg(REG_FIRST_DECAY, {8'd0, b1});
    write_reg(REG_SECOND_DECAY, {8'd0, b2});
    write_reg(REG_UNMAPPED, CFG_DATA_W'($urandom));
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  // wait for every predicted word and for the pipeline to empty
  task automatic drain();
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // offer one word, idling first at random, hold until taken
  task automatic send_word(input logic [15:0] addr, input logic [31:0] grad,
                           input logic [31:0] val);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      param_ch.valid <= 1'b0;
      @(negedge clk);
    end
    param_ch.valid                 <= 1'b1;
    param_ch.payload.param_address <= addr;
    param_ch.payload.gradient      <= grad;
    param_ch.payload.current_value <= val;
    do @(posedge clk); while (!param_ch.ready);
  endtask

  task automatic stop_sending();
    @(negedge clk);
    param_ch.valid <= 1'b0;
  endtask

  function automatic logic [31:0] pick_q824();
    case ($urandom_range(3))
      0: return $urandom;
      1: return $urandom_range(32'h0100_0000) * ($urandom_range(1) ? 1 : -1);
      2: return $urandom_range(32'h0000_4000) * ($urandom_range(1) ? 1 : -1);
      default: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
    endcase
  endfunction

  initial begin
    logic [15:0] addr;
    hold_off       = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    cfg_write      = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    param_ch.valid   = 1'b0;
    param_ch.payload = '0;
    rst = 1'b1;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: field extremes, repeat hits, saturation both ways
    send_word(16'd0, 32'h7FFF_FFFF, 32'h0000_0000);
    send_word(16'd0, 32'h8000_0000, 32'h7FFF_FFFF);
    send_word(16'hFFFF, 32'h8000_0000, 32'h8000_0000);
    send_word(16'hFFFF, 32'h0000_0000, 32'h0000_0000);
    send_word(16'd1, 32'h0000_0001, 32'hFFFF_FFFF);
    send_word(16'd1, 32'hFFFF_FFFF, 32'h0100_0000);
    send_word(16'd2, 32'h0100_0000, 32'h8000_0000);
    stop_sending();
    drain();
    // largest step, no memory in the moments
    set_regs(24'hFFFFFF, 16'd0, 16'd0);
    send_word(16'd3, 32'h8000_0000, 32'h7FFF_FFFF);
    send_word(16'd3, 32'h7FFF_FFFF, 32'h8000_0000);
    send_word(16'd4, 32'h0000_0001, 32'h8000_0000);
    send_word(16'd4, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
    send_word(16'h8000, 32'h5555_5555, 32'hAAAA_AAAA);
    stop_sending();
    drain();
    // zero step: values pass through while moments keep moving
    set_regs(24'd0, 16'hFFFF, 16'hFFFF);
    send_word(16'd0, 32'h7FFF_FFFF, 32'h1234_5678);
    send_word(16'd0, 32'h8000_0000, 32'h8000_0000);
    send_word(16'h7FFF, 32'hAAAA_AAAA, 32'h5555_5555);
    send_word(16'd5, 32'h0000_0000, 32'h7FFF_FFFF);
    stop_sending();
    drain();

    // random phases: register setting and idle pattern per phase
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: set_regs(LEARNING_RATE_RESET, FIRST_DECAY_RESET, SECOND_DECAY_RESET);
        1: set_regs(24'hFFFFFF, 16'hFFFF, 16'd0);
        2: set_regs(24'd0, 16'd0, 16'hFFFF);
        default: set_regs(24'($urandom), 16'($urandom), 16'($urandom));
      endcase
      case (p)
        1: begin send_idle_pct = 52; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 52; end
        3: begin send_idle_pct = 28; recv_stall_pct = 28; end
        4: begin send_idle_pct = 0;  recv_stall_pct = 0; hold_off = 1'b1; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      for (int n = 0; n < 175; n++) begin
        // mostly a small pool of addresses so moments build up
        case ($urandom_range(9))
          0, 1: addr = 16'($urandom);
          2:    addr = 16'hFFF0 | 16'($urandom_range(15));
          default: addr = 16'($urandom_range(15));
        endcase
        send_word(addr, pick_q824(), pick_q824());
      end
      stop_sending();
      drain();
    end

    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: sim.f
src/amsgrad_pkg.sv
src/amsgrad_stream_if.sv
src/amsgrad_ram.sv
src/amsgrad_sqrt.sv
src/amsgrad_div.sv
src/amsgrad_parameter_update.sv
verif/amsgrad_update_checker.sv
verif/amsgrad_parameter_update_test.sv
